// ===== hdl/ps2_mouse_packet_events_core_defines.svh =====
// ----------------------------------------------------------------------------
// ps2 mouse packet events: assertion macros
// shared concurrent check forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_EVENTS_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_EVENTS_CORE_DEFINES_SVH

// same-cycle implication
`define PS2PE_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PS2PE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ps2pe_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2pe_pkg
// types and constants shared by the ps2 mouse packet event decoder
// ----------------------------------------------------------------------------
package ps2pe_pkg;

   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned AUX_DATA_BIT = 5;
   localparam logic [1:0]  FIRST_SLOT   = 2'd0;
   localparam logic [1:0]  LAST_SLOT    = 2'd2;

   typedef enum logic [1:0] {
      EV_MOVE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   // one completed packet, as handed from front to back
   typedef struct packed {
      logic              move;
      logic [2:0]        change;
      logic [2:0]        held;
      logic signed [7:0] dx;
      logic signed [8:0] dy;
   } pkt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hdl/ps2pe_front.sv =====
// ----------------------------------------------------------------------------
// ps2pe_front
// accepts bytes, assembles three-byte packets, classifies the events of each
// ----------------------------------------------------------------------------
module ps2pe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_status_byte,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_write_enable,
   input  logic [0:0]          csr_write_data,
   input  ps2pe_pkg::q_stat_type q_stat,
   output logic                push,
   output ps2pe_pkg::pkt_type  push_data
);

   logic [7:0] bytes_ff [3];
   logic [7:0] bytes_in [3];
   logic [1:0] slot_ff, slot_in;
   logic [2:0] held_ff, held_in;
   logic       listen_ff, listen_in;

   logic       accept;
   logic       aux;
   logic [1:0] slot_eff;
   logic       complete;
   logic [7:0] b0, b1, b2;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign aux       = req_status_byte[ps2pe_pkg::AUX_DATA_BIT];
   // slot three cannot occur, read it as the first slot
   assign slot_eff  = (slot_ff == 2'd3) ? ps2pe_pkg::FIRST_SLOT : slot_ff;
   assign complete  = accept && aux && listen_ff && (slot_eff == ps2pe_pkg::LAST_SLOT);

   assign b0 = bytes_ff[0];
   assign b1 = bytes_ff[1];
   assign b2 = req_data_byte;

   always_comb begin
      bytes_in  = bytes_ff;
      slot_in   = slot_ff;
      held_in   = held_ff;
      listen_in = csr_write_enable ? csr_write_data[0] : listen_ff;
      if (accept && aux) begin
         bytes_in[slot_eff] = req_data_byte;
         if (listen_ff) begin
            slot_in = (slot_eff == ps2pe_pkg::LAST_SLOT) ? ps2pe_pkg::FIRST_SLOT
                                                         : slot_eff + 2'd1;
         end
      end
      if (complete) begin
         held_in = b0[2:0];
      end
   end

   always_comb begin
      push_data.move   = (b1 != 8'd0) || (b2 != 8'd0);
      push_data.change = b0[2:0] ^ held_ff;
      push_data.held   = held_ff;
      push_data.dx     = $signed(b1);
      push_data.dy     = $signed(9'd0 - {b2[7], b2});
      // a quiet packet leaves nothing to report
      push = complete && (push_data.move || (push_data.change != 3'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff[0] <= 8'd0;
         bytes_ff[1] <= 8'd0;
         bytes_ff[2] <= 8'd0;
         slot_ff     <= ps2pe_pkg::FIRST_SLOT;
         held_ff     <= 3'd0;
         listen_ff   <= 1'b1;
      end else begin
         bytes_ff  <= bytes_in;
         slot_ff   <= slot_in;
         held_ff   <= held_in;
         listen_ff <= listen_in;
      end
   end

endmodule

// ===== hdl/ps2pe_queue.sv =====
// ----------------------------------------------------------------------------
// ps2pe_queue
// small packet queue between the front and back parts
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_events_core_defines.svh"

module ps2pe_queue #(
   parameter int unsigned DEPTH = ps2pe_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ps2pe_pkg::pkt_type     push_data,
   input  logic                   pop,
   output ps2pe_pkg::pkt_type     pop_data,
   output ps2pe_pkg::q_stat_type  stat
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ps2pe_pkg::pkt_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == CNT_W'(0));
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= PTR_W'(0);
         rd_ptr_ff <= PTR_W'(0);
         count_ff  <= CNT_W'(0);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PS2PE_ASSERT_IMPLY(a_no_overflow, push, !stat.full, "packet pushed into full queue")
   `PS2PE_ASSERT_IMPLY(a_no_underflow, pop, !stat.empty, "packet popped from empty queue")
   `PS2PE_ASSERT_NEXT(a_push_lands, push && !pop, !stat.empty, "pushed packet not held")

endmodule

// ===== hdl/ps2pe_back.sv =====
// ----------------------------------------------------------------------------
// ps2pe_back
// turns each packet into move and button events, one per cycle unless stalled
// ----------------------------------------------------------------------------
module ps2pe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ps2pe_pkg::q_stat_type q_stat,
   input  ps2pe_pkg::pkt_type    pop_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_event_kind,
   output logic signed [7:0]     rsp_delta_x,
   output logic signed [8:0]     rsp_delta_y,
   output logic [1:0]            rsp_button_number,
   output logic                  rsp_last_event
);

   // pending events: bit 0 move, bits 1 to 3 buttons 1 to 3
   logic [3:0]        pend_ff, pend_in;
   logic signed [7:0] wdx_ff, wdx_in;
   logic signed [8:0] wdy_ff, wdy_in;
   logic [2:0]        wheld_ff, wheld_in;

   logic                      valid_ff, valid_in;
   ps2pe_pkg::event_kind_type kind_ff, kind_in;
   logic signed [7:0]         dx_ff, dx_in;
   logic signed [8:0]         dy_ff, dy_in;
   logic [1:0]                btn_ff, btn_in;
   logic                      last_ff, last_in;

   logic       out_free;
   logic       have_work;
   logic [3:0] sel;
   logic [3:0] rest;

   assign out_free  = !valid_ff || !rsp_stall;
   assign have_work = (pend_ff != 4'd0);
   assign rest      = pend_ff & ~sel;

   always_comb begin
      sel = 4'd0;
      priority if (pend_ff[0]) begin
         sel = 4'b0001;
      end else if (pend_ff[1]) begin
         sel = 4'b0010;
      end else if (pend_ff[2]) begin
         sel = 4'b0100;
      end else if (pend_ff[3]) begin
         sel = 4'b1000;
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      wdx_in   = wdx_ff;
      wdy_in   = wdy_ff;
      wheld_in = wheld_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      btn_in   = btn_ff;
      last_in  = last_ff;

      if (out_free) begin
         valid_in = have_work;
         if (have_work) begin
            pend_in = rest;
            last_in = (rest == 4'd0);
            priority if (sel[0]) begin
               kind_in = ps2pe_pkg::EV_MOVE;
               dx_in   = wdx_ff;
               dy_in   = wdy_ff;
               btn_in  = 2'd0;
            end else if (sel[1]) begin
               kind_in = wheld_ff[0] ? ps2pe_pkg::EV_RELEASE : ps2pe_pkg::EV_PRESS;
               dx_in   = 8'sd0;
               dy_in   = 9'sd0;
               btn_in  = 2'd1;
            end else if (sel[2]) begin
               kind_in = wheld_ff[1] ? ps2pe_pkg::EV_RELEASE : ps2pe_pkg::EV_PRESS;
               dx_in   = 8'sd0;
               dy_in   = 9'sd0;
               btn_in  = 2'd2;
            end else begin
               kind_in = wheld_ff[2] ? ps2pe_pkg::EV_RELEASE : ps2pe_pkg::EV_PRESS;
               dx_in   = 8'sd0;
               dy_in   = 9'sd0;
               btn_in  = 2'd3;
            end
         end
      end

      // refill as the last pending event goes out, so packets run back to back
      pop = !q_stat.empty && (!have_work || (out_free && (rest == 4'd0)));
      if (pop) begin
         pend_in  = {pop_data.change, pop_data.move};
         wdx_in   = pop_data.dx;
         wdy_in   = pop_data.dy;
         wheld_in = pop_data.held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wdx_ff   <= wdx_in;
      wdy_ff   <= wdy_in;
      wheld_ff <= wheld_in;
      kind_ff  <= kind_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      btn_ff   <= btn_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_delta_x       = dx_ff;
   assign rsp_delta_y       = dy_ff;
   assign rsp_button_number = btn_ff;
   assign rsp_last_event    = last_ff;

endmodule

// ===== hdl/ps2_mouse_packet_events_core.sv =====
// The block takes one request (status byte, data byte) per cycle unless stalled
// and turns each completed three-byte mouse packet into up to four events: a
// move, then button press or release events for buttons 1 to 3, the last one
// flagged. Requests whose status bit 5 is clear are taken and ignored. A
// packet's events leave one per cycle from the output register while rsp_stall
// is low; completed packets wait in a queue of QUEUE_DEPTH entries, and
// req_stall is high only while that queue is full. Writing csr_write_data to
// 0 stops the packet slot from advancing; after reset the listener is attached.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_events_core
// ps2 mouse three-byte packet decoder with event output
// ----------------------------------------------------------------------------
module ps2_mouse_packet_events_core #(
   parameter int unsigned QUEUE_DEPTH = ps2pe_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_status_byte,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_event_kind,
   output logic signed [7:0] rsp_delta_x,
   output logic signed [8:0] rsp_delta_y,
   output logic [1:0]        rsp_button_number,
   output logic              rsp_last_event,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_write_data
);

   ps2pe_pkg::q_stat_type q_stat;
   ps2pe_pkg::pkt_type    push_data;
   ps2pe_pkg::pkt_type    pop_data;
   logic                  push;
   logic                  pop;

   ps2pe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_status_byte  (req_status_byte),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_stat           (q_stat),
      .push             (push),
      .push_data        (push_data)
   );

   ps2pe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   ps2pe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_button_number (rsp_button_number),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

// ===== tb/tb_ps2_mouse_packet_events_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_events_core
// feeds status/data byte pairs into the mouse packet decoder with bursty
// requests and a stalling event sink; a local decoder predicts every event
// and each one leaving the block is checked field by field, in order
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_events_core;

   localparam int          SETTLE_CYCLES = 16;
   localparam int          TIMEOUT_NS    = 2_000_000;
   localparam logic [7:0]  AUX_FLAG      = 8'(1 << ps2pe_pkg::AUX_DATA_BIT);

   typedef struct {
      logic [7:0] status;
      logic [7:0] data;
   } mouse_byte_type;

   typedef struct {
      ps2pe_pkg::event_kind_type kind;
      logic signed [7:0]         dx;
      logic signed [8:0]         dy;
      logic [1:0]                button;
      logic                      last;
   } mouse_event_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_status_byte = '0;
   logic [7:0]        req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_event_kind;
   logic signed [7:0] rsp_delta_x;
   logic signed [8:0] rsp_delta_y;
   logic [1:0]        rsp_button_number;
   logic              rsp_last_event;
   logic              csr_write_enable = 1'b0;
   logic [0:0]        csr_write_data = '0;

   // local copy of the decoder state
   logic [7:0]   packet_store [3] = '{8'h00, 8'h00, 8'h00};
   logic [1:0]   packet_slot = ps2pe_pkg::FIRST_SLOT;
   logic [2:0]   held_buttons = 3'b000;
   logic         listener_attached = 1'b1;

   mouse_byte_type  mouse_bytes [$];
   mouse_event_type expected_events [$];
   int              queued_count = 0;
   int              accepted_count = 0;
   int              error_count = 0;
   int              burst_left = 4;
   int              gap_left = 0;
   int              stall_mode = 0;
   int              stall_hold = 0;
   int unsigned     cycle_count = 0;

   ps2_mouse_packet_events_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_status_byte   (req_status_byte),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_button_number (rsp_button_number),
      .rsp_last_event    (rsp_last_event),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #10 clock = ~clock;

   function automatic void decode_mouse_byte(input logic [7:0] status,
                                             input logic [7:0] data);
      mouse_event_type events [4];
      int              n;
      n = 0;
      if (packet_slot > ps2pe_pkg::LAST_SLOT) packet_slot = ps2pe_pkg::FIRST_SLOT;
      if (!status[ps2pe_pkg::AUX_DATA_BIT]) return;
      packet_store[packet_slot] = data;
      if (!listener_attached) return;
      packet_slot = (packet_slot == ps2pe_pkg::LAST_SLOT) ? ps2pe_pkg::FIRST_SLOT
                                                          : packet_slot + 2'd1;
      if (packet_slot != ps2pe_pkg::FIRST_SLOT) return;
      if (packet_store[1] != 8'h00 || packet_store[2] != 8'h00) begin
         events[n].kind   = ps2pe_pkg::EV_MOVE;
         events[n].dx     = $signed(packet_store[1]);
         events[n].dy     = -$signed({packet_store[2][7], packet_store[2]});
         events[n].button = 2'd0;
         events[n].last   = 1'b0;
         n++;
      end
      for (int i = 0; i < 3; i++) begin
         if (packet_store[0][i] != held_buttons[i]) begin
            events[n].kind   = held_buttons[i] ? ps2pe_pkg::EV_RELEASE
                                               : ps2pe_pkg::EV_PRESS;
            events[n].dx     = '0;
            events[n].dy     = '0;
            events[n].button = 2'(i + 1);
            events[n].last   = 1'b0;
            n++;
         end
      end
      if (n > 0) events[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_events.push_back(events[i]);
      held_buttons = packet_store[0][2:0];
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_status_byte <= '0;
         req_data_byte   <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_mouse_byte(req_status_byte, req_data_byte);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (mouse_bytes.size() > 0) begin
               mouse_byte_type b;
               b = mouse_bytes.pop_front();
               req_valid       <= 1'b1;
               req_status_byte <= b.status;
               req_data_byte   <= b.data;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // event monitor and sink stall pattern
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual kind %0d button %0d",
                     $time, rsp_event_kind, rsp_button_number);
            error_count++;
         end else begin
            mouse_event_type e;
            e = expected_events.pop_front();
            check_field("event_kind", int'(e.kind), int'(rsp_event_kind));
            check_field("delta_x", int'(e.dx), int'(rsp_delta_x));
            check_field("delta_y", int'(e.dy), int'(rsp_delta_y));
            check_field("button_number", int'(e.button), int'(rsp_button_number));
            check_field("last_event", int'(e.last), int'(rsp_last_event));
         end
      end
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_hold = $urandom_range(32, 96);
      end else begin
         stall_hold--;
      end
      unique case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[1];
      endcase
   end

   task automatic queue_byte(input logic [7:0] status, input logic [7:0] data);
      mouse_byte_type b;
      b.status = status;
      b.data   = data;
      mouse_bytes.push_back(b);
      queued_count++;
   endtask

   function automatic logic [7:0] aux_status();
      return 8'($urandom_range(0, 255)) | AUX_FLAG;
   endfunction

   function automatic logic [7:0] noise_status();
      return 8'($urandom_range(0, 255)) & ~AUX_FLAG;
   endfunction

   // mostly framed packets, with stray non-mouse bytes and the odd extra byte
   task automatic queue_random_packet();
      logic [7:0] dx;
      logic [7:0] dy;
      dx = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      dy = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      if ($urandom_range(0, 5) == 0) queue_byte(noise_status(), 8'($urandom));
      queue_byte(aux_status(), 8'($urandom));
      if ($urandom_range(0, 5) == 0) queue_byte(noise_status(), 8'($urandom));
      queue_byte(aux_status(), dx);
      queue_byte(aux_status(), dy);
      if ($urandom_range(0, 15) == 0) queue_byte(aux_status(), 8'($urandom));
   endtask

   task automatic write_listener(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      listener_attached = value;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic listener_value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_listener(1'b1);
      // bytes without the aux flag are dropped
      queue_byte(8'h00, 8'h55);
      queue_byte(8'hDF, 8'hFF);
      // all buttons pressed, largest positive dx, dy byte -128
      queue_byte(8'h20, 8'h07);
      queue_byte(8'hFF, 8'h7F);
      queue_byte(8'h20, 8'h80);
      // all released, most negative dx, dy byte 127, non-mouse byte mid packet
      queue_byte(8'h28, 8'h00);
      queue_byte(8'h00, 8'hAA);
      queue_byte(8'h20, 8'h80);
      queue_byte(8'h20, 8'h7F);
      // quiet packet
      queue_byte(8'h20, 8'h00);
      queue_byte(8'h20, 8'h00);
      queue_byte(8'h20, 8'h00);
      // move only
      queue_byte(8'h20, 8'h08);
      queue_byte(8'h20, 8'h01);
      queue_byte(8'h20, 8'h00);
      // button 2 press only
      queue_byte(8'h20, 8'h02);
      queue_byte(8'h20, 8'h00);
      queue_byte(8'h20, 8'h00);
      // held button unchanged, upper bits set, move with dx -1
      queue_byte(8'h20, 8'hFA);
      queue_byte(8'h20, 8'hFF);
      queue_byte(8'h20, 8'h01);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         listener_value = (phase == 2 || phase == 5) ? 1'b0 : 1'b1;
         write_listener(listener_value);
         if (listener_value) begin
            repeat (7) queue_random_packet();
         end else begin
            // detached: aux-flagged bytes land in the current slot, no events
            repeat (8) queue_byte(8'($urandom), 8'($urandom));
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ps2pe_pkg.sv
hdl/ps2pe_front.sv
hdl/ps2pe_queue.sv
hdl/ps2pe_back.sv
hdl/ps2_mouse_packet_events_core.sv
tb/tb_ps2_mouse_packet_events_core.sv
